>>> rtl/sspq_pkg.sv
// Shared constants, codes and types of the sorted stack priority queue.
package sspq_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_POP    = 2'd1;
    localparam logic [1:0] ACT_PEEK   = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic signed [31:0] MOST_NEG = 32'sh8000_0000;
    localparam logic signed [31:0] MOST_POS = 32'sh7FFF_FFFF;

    // Command broadcast to every cell of the chain at once.
    typedef struct packed {
        logic              ins;
        logic              pop;
        logic signed [31:0] value;
    } cell_ctl_t;

endpackage

>>> rtl/sspq_cell.sv
// One storage cell of the sorted chain: holds a value and shifts with its neighbours.
module sspq_cell
(
    input  logic                clk,
    input  sspq_pkg::cell_ctl_t ctl,
    input  logic                occupied,
    input  logic                gt_in,
    output logic                gt_out,
    input  logic signed [31:0]  up_val,
    input  logic signed [31:0]  down_val,
    output logic signed [31:0]  val
);

    logic signed [31:0] val_reg;
    logic signed [31:0] val_next;

    // True when this cell holds a value strictly greater than the one offered.
    assign gt_out = occupied && (val_reg > ctl.value);
    assign val    = val_reg;

    always_comb
    begin
        val_next = val_reg;
        if (ctl.ins)
        begin
            if (!gt_out)
            begin
                // The first cell not greater takes the new value; those below shift down.
                val_next = gt_in ? ctl.value : up_val;
            end
        end
        else if (ctl.pop)
        begin
            val_next = down_val;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

endmodule

>>> rtl/sorted_stack_priority_queue_unit.sv
// Top level of the sorted stack priority queue: a chain of value cells and the count register.
//
// The queue keeps up to CAPACITY signed 32-bit values in a row of cells ordered from the largest,
// in the first cell, downwards. Every request is handled without a stall: it is accepted when
// start is high and busy is low, all cells compare the offered value in parallel and shift down
// (insert) or up (pop) at that same edge, and the result appears on the next cycle with done high
// for exactly that one cycle. The cell chain updates at the accepting edge, so busy stays low and a
// new request may follow in every cycle. There is no way to hold results back: the receiver must
// take each one in the cycle in which done is high. A pop of an empty queue returns the most
// negative value and a peek of an empty queue the most positive, both with status empty; an
// insert into a full queue is dropped and reported with status full. Every result carries the
// element count after the request, and the undefined action code three leaves the queue alone.
module sorted_stack_priority_queue_unit
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         action,
    input  logic signed [31:0] value,
    output logic               done,
    output logic signed [31:0] result_value,
    output logic [1:0]         status,
    output logic [4:0]         element_count
);

    localparam int N = sspq_pkg::CAPACITY;
    localparam int W = sspq_pkg::CNT_W;

    logic [W-1:0]       count_reg;
    logic [W-1:0]       count_next;
    logic               done_reg;
    logic signed [31:0] result_reg;
    logic signed [31:0] result_next;
    logic [1:0]         status_reg;
    logic [1:0]         status_next;
    logic [31:0]        count_wide;

    logic                cmd_accept;
    logic                is_empty;
    logic                is_full;
    sspq_pkg::cell_ctl_t ctl;

    logic signed [31:0] cell_val [N];
    logic               gt_chain [N+1];

    // Requests are taken in every cycle; the chain updates at the accepting edge.
    assign busy       = 1'b0;
    assign cmd_accept = start && !busy;
    assign is_empty   = (count_reg == '0);
    assign is_full    = (count_reg == W'(N));

    always_comb
    begin
        ctl.value = value;
        ctl.ins   = cmd_accept && (action == sspq_pkg::ACT_INSERT) && !is_full;
        ctl.pop   = cmd_accept && (action == sspq_pkg::ACT_POP) && !is_empty;
    end

    // The cell above the first one counts as greater, so an insert always lands somewhere.
    assign gt_chain[0] = 1'b1;

    genvar gi;
    generate
        for (gi = 0; gi < N; gi++)
        begin : g_cell
            logic signed [31:0] up_v;
            logic signed [31:0] down_v;
            logic               occ;

            assign occ = (count_reg > W'(gi));

            if (gi == 0)
            begin : g_first
                assign up_v = value;
            end
            else
            begin : g_mid
                assign up_v = cell_val[gi-1];
            end

            if (gi == N - 1)
            begin : g_last
                assign down_v = '0;
            end
            else
            begin : g_inner
                assign down_v = cell_val[gi+1];
            end

            sspq_cell u_cell
            (
                .clk      (clk),
                .ctl      (ctl),
                .occupied (occ),
                .gt_in    (gt_chain[gi]),
                .gt_out   (gt_chain[gi+1]),
                .up_val   (up_v),
                .down_val (down_v),
                .val      (cell_val[gi])
            );
        end
    endgenerate

    // Result selection and the new element count.
    always_comb
    begin
        count_next  = count_reg;
        result_next = '0;
        status_next = sspq_pkg::ST_OK;
        case (action)
            sspq_pkg::ACT_INSERT:
            begin
                if (is_full)
                begin
                    status_next = sspq_pkg::ST_FULL;
                end
                else
                begin
                    count_next = count_reg + W'(1);
                end
            end
            sspq_pkg::ACT_POP:
            begin
                if (is_empty)
                begin
                    result_next = sspq_pkg::MOST_NEG;
                    status_next = sspq_pkg::ST_EMPTY;
                end
                else
                begin
                    result_next = cell_val[0];
                    count_next  = count_reg - W'(1);
                end
            end
            sspq_pkg::ACT_PEEK:
            begin
                if (is_empty)
                begin
                    result_next = sspq_pkg::MOST_POS;
                    status_next = sspq_pkg::ST_EMPTY;
                end
                else
                begin
                    result_next = cell_val[0];
                end
            end
            default:
            begin
                // The spare action code does nothing and reports success.
                result_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= cmd_accept;
            if (cmd_accept)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_accept)
        begin
            result_reg <= result_next;
            status_reg <= status_next;
        end
    end

    // The reported count is taken modulo 32.
    assign count_wide    = 32'(count_reg);
    assign done          = done_reg;
    assign result_value  = result_reg;
    assign status        = status_reg;
    assign element_count = count_wide[4:0];

endmodule

>>> rtl/sspq_checker.sv
// Port-level assertions for the sorted stack priority queue, bound to the top level.
module sspq_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic [1:0]         action,
    input logic               done,
    input logic [1:0]         status,
    input logic [4:0]         element_count
);

    // Every accepted request gives exactly one result on the following cycle.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> done)
        else $error("accepted request gave no result");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |=> !done)
        else $error("result without a request");

    // A dropped insert can only happen with the queue at capacity.
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == sspq_pkg::ST_FULL) |-> (element_count == 5'(sspq_pkg::CAPACITY)))
        else $error("full status with wrong count");

    // An empty answer leaves the count at zero, and comes from a pop or a peek.
    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == sspq_pkg::ST_EMPTY) |-> (element_count == 5'd0))
        else $error("empty status with non-zero count");

    a_empty_action: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && action == sspq_pkg::ACT_INSERT) |=> (status != sspq_pkg::ST_EMPTY))
        else $error("insert reported empty");

endmodule

bind sorted_stack_priority_queue_unit sspq_checker u_sspq_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .action        (action),
    .done          (done),
    .status        (status),
    .element_count (element_count)
);
